@@ src/sliding_window_mean_variance_unit_defines.svh @@
// Assertion macros for the sliding window mean/variance unit.
// Depends on nothing; taken in by the top level.
`ifndef SLIDING_WINDOW_MEAN_VARIANCE_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_VARIANCE_UNIT_DEFINES_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define SWMV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swmv check failed");

// Antecedent holds -> consequent holds in the next cycle.
`define SWMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmv check failed");

`endif

@@ src/swmv_pkg.sv @@
// Package for the sliding window mean/variance unit: sizes, states, structs.
// Depends on nothing.
`timescale 1ns / 1ps
package swmv_pkg;
   localparam int WINDOW        = 64;
   localparam int FRACTION_BITS = 16;
   localparam int SAMPLE_W      = 32;
   localparam int SPAN_W        = 7;
   localparam int VAR_W         = 64;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int CMP_W  = (FILL_W > SPAN_W) ? FILL_W : SPAN_W;
   localparam int SUM_W  = SAMPLE_W + IDX_W + 1;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int SQ_W   = 2 * SAMPLE_W + 1;
   localparam int ACC_W  = SQ_W + IDX_W;
   localparam int VSHIFT = 32 - 2 * FRACTION_BITS;
   localparam int LSH    = (VSHIFT > 0) ? VSHIFT : 0;
   localparam int RSH    = (VSHIFT < 0) ? -VSHIFT : 0;
   localparam int NUM_W  = ACC_W + LSH;
   localparam int DIV_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SUM, S_MSTART, S_MDIV, S_VAR, S_DRAIN, S_VSTART, S_VDIV_OUT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [FILL_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_W-1:0]   quotient;
   } div_rsp_type;
endpackage

@@ src/sliding_window_mean_variance_unit.sv @@
// Top level of the sliding window mean/variance unit.
// Depends on swmv_pkg, swmv_cell, swmv_div and the defines header.
//
// Usage:
//  - req_valid/req_sample/req_stall carry one Q16.16 sample per item.
//    rsp_valid/rsp_window_mean/rsp_window_variance/rsp_stall carry one
//    result per item: mean of the filled window (Q16.16, truncated toward
//    zero) and variance of the newest span samples about that mean
//    (Q32.32, saturating).
//  - csr_write_enable/csr_variance_span set the span; 0 = whole window.
//  - The window is a chain of WINDOW cells. A new item shifts in at cell 0.
//    Each pass rotates the chain WINDOW steps so cell 0 presents samples
//    newest to oldest, then the chain is back in place.
//  - Each item goes through a sum pass, a 1-bit/cycle mean division, a
//    pipelined square-and-add pass, and a 1-bit/cycle variance division
//    before rsp_valid. One item is worked on at a time; the next item is
//    taken in the cycle after the result loads.
//  - The result sits in an output register; a new item may be accepted
//    while it waits. If rsp_stall holds, the finished next result waits.
//  - Reset (synchronous) empties the window count and span and clears rsp_valid.
`timescale 1ns / 1ps
`include "sliding_window_mean_variance_unit_defines.svh"
module sliding_window_mean_variance_unit
   import swmv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                req_stall,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_window_mean,
   output logic [VAR_W-1:0]    rsp_window_variance,
   input  logic                rsp_stall,
   input  logic                csr_write_enable,
   input  logic [SPAN_W-1:0]   csr_variance_span
);
   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] cell_data [WINDOW];
   logic                load, rotate;

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SPAN_W-1:0]   span_ff;
   logic [FILL_W-1:0]   span_eff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]   mag_ff;
   logic                en_a_ff, en_a_in;
   logic [2*DIFF_W-1:0] prod;
   logic [SQ_W-1:0]     sq_ff;
   logic                en_b_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    sum_mag;
   logic [NUM_W-1:0]    var_num;
   logic [SAMPLE_W-1:0] qmean;
   logic [VAR_W-1:0]    var_res_ff, var_res_in;
   logic                out_load;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic [VAR_W-1:0]    rsp_var_ff;
   logic                in_window;
   logic                in_span;
   logic                last_step;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Window chain: shift toward the old end on load, toward cell 0 on a pass.
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      swmv_cell u_cell (
         .clock     (clock),
         .load      (load),
         .rotate    (rotate),
         .from_prev ((k == 0) ? req_sample : cell_data[(k + WINDOW - 1) % WINDOW]),
         .from_next (cell_data[(k + 1) % WINDOW]),
         .data      (cell_data[k])
      );
   end

   swmv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign load      = req_valid && !req_stall;
   assign rotate    = (state_ff == S_SUM) || (state_ff == S_VAR);
   assign last_step = (idx_ff == IDX_W'(WINDOW - 1));

   // Span of zero or beyond the fill count means the whole filled window.
   always_comb begin
      if ((span_ff == '0) || (CMP_W'(span_ff) > CMP_W'(fill_ff))) begin
         span_eff = fill_ff;
      end else begin
         span_eff = FILL_W'(span_ff);
      end
   end

   assign in_window = (FILL_W'(idx_ff) < fill_ff) || (FILL_W'(WINDOW) == FILL_W'(idx_ff));
   assign in_span   = (FILL_W'(idx_ff) < span_eff);

   // Square-and-add pipe: |mean - sample|, then square, then accumulate.
   assign diff    = {mean_ff[SAMPLE_W-1], mean_ff}
                  - {cell_data[0][SAMPLE_W-1], cell_data[0]};
   assign prod    = mag_ff * mag_ff;
   assign en_a_in = (state_ff == S_VAR) && in_span;

   assign sum_mag = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
   assign qmean   = div_rsp.quotient[SAMPLE_W-1:0];
   assign var_num = (NUM_W'(acc_ff) << LSH) >> RSH;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      mean_in    = mean_ff;
      acc_in     = en_b_ff ? (acc_ff + ACC_W'(sq_ff)) : acc_ff;
      var_res_in = var_res_ff;
      out_load   = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(sum_mag);
      div_req.divisor  = fill_ff;
      case (state_ff)
         S_IDLE: begin
            if (load) begin
               if (fill_ff != FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + 1'b1;
               end
               sum_in   = '0;
               idx_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (in_window) begin
               sum_in = sum_ff + {{(SUM_W-SAMPLE_W){cell_data[0][SAMPLE_W-1]}}, cell_data[0]};
            end
            idx_in = idx_ff + 1'b1;
            if (last_step) begin
               state_in = S_MSTART;
            end
         end
         S_MSTART: begin
            div_req.start = 1'b1;
            state_in      = S_MDIV;
         end
         S_MDIV: begin
            if (div_rsp.done) begin
               mean_in  = sum_ff[SUM_W-1] ? (SAMPLE_W'(0) - qmean) : qmean;
               acc_in   = '0;
               idx_in   = '0;
               state_in = S_VAR;
            end
         end
         S_VAR: begin
            idx_in = idx_ff + 1'b1;
            if (last_step) begin
               idx_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(1) || IDX_W == 1 && idx_ff != '0) begin
               state_in = S_VSTART;
            end
         end
         S_VSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(var_num);
            div_req.divisor  = span_eff;
            state_in         = S_VDIV_OUT;
         end
         S_VDIV_OUT: begin
            // Quotient stays in the divider after done; wait for the output slot.
            if (div_rsp.done) begin
               var_res_in = (|div_rsp.quotient[DIV_W-1:VAR_W]) ? '1
                          : div_rsp.quotient[VAR_W-1:0];
               idx_in     = IDX_W'(1);
            end
            if ((idx_ff == IDX_W'(1)) && (!rsp_valid_ff || !rsp_stall)) begin
               out_load = 1'b1;
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      mean_ff    <= mean_in;
      mag_ff     <= diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
      sq_ff      <= prod[SQ_W-1:0];
      acc_ff     <= acc_in;
      var_res_ff <= var_res_in;
      if (out_load) begin
         rsp_mean_ff <= mean_ff;
         rsp_var_ff  <= var_res_ff;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         fill_ff      <= '0;
         span_ff      <= '0;
         en_a_ff      <= 1'b0;
         en_b_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         en_a_ff      <= en_a_in;
         en_b_ff      <= en_a_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            span_ff <= csr_variance_span;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_window_mean     = rsp_mean_ff;
   assign rsp_window_variance = rsp_var_ff;

   `SWMV_ASSERT_NEXT(a_accept_starts_sum, clock, reset, req_valid && !req_stall, state_ff == S_SUM)
   `SWMV_ASSERT_SAME(a_fill_bounded, clock, reset, 1'b1, fill_ff <= FILL_W'(WINDOW))
   `SWMV_ASSERT_SAME(a_fill_nonzero_busy, clock, reset, state_ff != S_IDLE, fill_ff != '0)
endmodule

@@ src/swmv_cell.sv @@
// One window cell: holds a sample, shifts in on load, rotates on pass steps.
// Depends on swmv_pkg.
`timescale 1ns / 1ps
module swmv_cell
   import swmv_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic                rotate,
   input  logic [SAMPLE_W-1:0] from_prev,
   input  logic [SAMPLE_W-1:0] from_next,
   output logic [SAMPLE_W-1:0] data
);
   logic [SAMPLE_W-1:0] data_ff;
   logic [SAMPLE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = from_prev;
      end else if (rotate) begin
         data_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

@@ src/swmv_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by mean and variance.
// Depends on swmv_pkg.
`timescale 1ns / 1ps
module swmv_div
   import swmv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [FILL_W-1:0] dvs_ff, dvs_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [FILL_W:0]   rem_sh;
   logic [FILL_W:0]   rem_sub;
   logic              qbit;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      qbit    = (rem_sh >= {1'b0, dvs_ff});
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], qbit};
         rem_in = qbit ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;
endmodule
